// ----- sv/eisu_pkg.sv -----
`timescale 1ns / 1ps
// Package for the semi-implicit species update block.
// Holds the word types, command and status structs and constants; no dependencies.
package eisu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned AccW  = 2 * DataW;

  localparam logic [DataW-1:0] AllOnes    = '1;
  localparam logic [DataW-1:0] OneQ40     = 64'h0000_0100_0000_0000;
  localparam logic [DataW-1:0] RhoRepMin  = 64'd110;
  localparam logic [CfgW-1:0]  CTauReset  = 32'd1677722;

  typedef struct packed {
    logic [DataW-1:0] density_in;
    logic signed [DataW-1:0] net_rate;
    logic [DataW-1:0] sub_step;
    logic             last_species;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] density_out;
    logic [DataW-1:0] next_step;
    logic             last_out;
  } out_word_t;

  typedef enum logic [1:0] {
    PH_TAU = 2'd0,
    PH_Q   = 2'd1,
    PH_N   = 2'd2
  } phase_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_idx;
    logic       div_load;
    logic       div_step;
    phase_e     phase;
    logic       post;
    logic       out_load;
  } eisu_cmd_t;

  typedef struct packed {
    logic rate_zero;
  } eisu_status_t;

endpackage

// ----- sv/eisu_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: input and config registers, shared 32x32 multiplier with accumulator,
// radix-two divider, running minimum and output register. Depends on eisu_pkg.
module eisu_datapath import eisu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_word_t         in_word_i,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  eisu_cmd_t        cmd_i,
  output eisu_status_t     status_o,
  output out_word_t        out_word_o
);

  logic [DataW-1:0] rho_q, rate_q, dt_q;
  logic             last_q;
  logic [CfgW-1:0]  c_q;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [DataW-1:0] rem_q, rem_d, dlo_q, dlo_d, quo_q, quo_d, dvs_q, dvs_d;
  logic             sat_q, sat_d;
  logic [DataW-1:0] run_q, run_d, den_q;
  out_word_t        out_q;

  logic [DataW-1:0] dest, prod, ma, mb, dhi, dlo, dd, num, tp, quo_res, rho_fl, rho_rep;
  logic [31:0]      pa, pb;
  logic [63:0]      pp;
  logic [AccW-1:0]  pp_sh;
  logic [DataW:0]   rem_s, sum_n, sum_d;

  always_comb begin
    dest    = rate_q[DataW-1] ? (~rate_q + 1'b1) : '0;
    prod    = rate_q[DataW-1] ? '0 : rate_q;
    rho_fl  = (rho_q > 64'd1) ? rho_q : 64'd1;
    rho_rep = (rho_q > RhoRepMin) ? rho_q : RhoRepMin;
    quo_res = sat_q ? AllOnes : quo_q;
    status_o.rate_zero = (rate_q == '0);

    unique case (cmd_i.phase)
      PH_TAU: begin
        ma = (dest != '0) ? rho_q : rho_rep;
        mb = {{(DataW-CfgW){1'b0}}, c_q};
      end
      PH_Q: begin
        ma = dt_q;
        mb = dest;
      end
      default: begin
        ma = dt_q;
        mb = prod;
      end
    endcase

    pa = cmd_i.mul_idx[1] ? ma[63:32] : ma[31:0];
    pb = cmd_i.mul_idx[0] ? mb[63:32] : mb[31:0];
    pp = pa * pb;
    unique case (cmd_i.mul_idx)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    acc_d = (cmd_i.mul_idx == 2'd0) ? pp_sh : (acc_q + pp_sh);

    tp    = (acc_q[127:104] != '0) ? AllOnes : acc_q[103:40];
    sum_n = {1'b0, rho_q} + {1'b0, tp};
    num   = sum_n[DataW] ? AllOnes : sum_n[DataW-1:0];
    sum_d = {1'b0, OneQ40} + {1'b0, quo_res};

    unique case (cmd_i.phase)
      PH_TAU: begin
        dhi = acc_q[111:48];
        dlo = {acc_q[47:0], 16'd0};
        dd  = dest | prod;
      end
      PH_Q: begin
        dhi = acc_q[127:64];
        dlo = acc_q[63:0];
        dd  = rho_fl;
      end
      default: begin
        dhi = {24'd0, num[63:24]};
        dlo = {num[23:0], 40'd0};
        dd  = den_q;
      end
    endcase

    rem_s = {rem_q, dlo_q[DataW-1]};
    rem_d = rem_q;
    dlo_d = dlo_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    sat_d = sat_q;
    if (cmd_i.div_load) begin
      rem_d = dhi;
      dlo_d = dlo;
      quo_d = '0;
      dvs_d = dd;
      sat_d = (dhi >= dd);
    end else if (cmd_i.div_step) begin
      dlo_d = {dlo_q[DataW-2:0], 1'b0};
      if (rem_s >= {1'b0, dvs_q}) begin
        rem_d = rem_s[DataW-1:0] - dvs_q;
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_s[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
    end

    run_d = run_q;
    if (cmd_i.post && cmd_i.phase == PH_TAU && quo_res < run_q) begin
      run_d = quo_res;
    end else if (cmd_i.out_load && last_q) begin
      run_d = AllOnes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q   <= CTauReset;
      run_q <= AllOnes;
    end else begin
      if (cfg_we_i) begin
        c_q <= cfg_wdata_i;
      end
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rho_q  <= in_word_i.density_in;
      rate_q <= in_word_i.net_rate;
      dt_q   <= in_word_i.sub_step;
      last_q <= in_word_i.last_species;
    end
    if (cmd_i.mul_en) begin
      acc_q <= acc_d;
    end
    rem_q <= rem_d;
    dlo_q <= dlo_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    sat_q <= sat_d;
    if (cmd_i.post && cmd_i.phase == PH_Q) begin
      den_q <= sum_d[DataW] ? AllOnes : sum_d[DataW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.density_out <= quo_res;
      out_q.next_step   <= last_q ? ((run_q < dt_q) ? run_q : dt_q) : '0;
      out_q.last_out    <= last_q;
    end
  end

  assign out_word_o = out_q;

endmodule

// ----- sv/eisu_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences multiply and divide passes and the handshakes.
// Depends on eisu_pkg.
module eisu_ctrl import eisu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  eisu_status_t status_i,
  output eisu_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_DLOAD = 6'b000100,
    S_DIV   = 6'b001000,
    S_POST  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] mcnt_q, mcnt_d;
  logic [5:0] dcnt_q, dcnt_d;
  logic       ovld_q, ovld_d;
  logic       in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    mcnt_d  = mcnt_q;
    dcnt_d  = dcnt_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.phase    = phase_q;
    cmd_o.mul_idx  = mcnt_q;
    cmd_o.load     = in_acc;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL;
          mcnt_d  = '0;
          phase_d = PH_TAU;
        end
      end
      S_MUL: begin
        if (phase_q == PH_TAU && status_i.rate_zero) begin
          phase_d = PH_Q;
        end else begin
          cmd_o.mul_en = 1'b1;
          mcnt_d       = mcnt_q + 2'd1;
          if (mcnt_q == 2'd3) begin
            state_d = S_DLOAD;
          end
        end
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        dcnt_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        cmd_o.post = 1'b1;
        mcnt_d     = '0;
        unique case (phase_q)
          PH_TAU: begin
            phase_d = PH_Q;
            state_d = S_MUL;
          end
          PH_Q: begin
            phase_d = PH_N;
            state_d = S_MUL;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_OUT: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovld_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_TAU;
      mcnt_q  <= '0;
      dcnt_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      mcnt_q  <= mcnt_d;
      dcnt_q  <= dcnt_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

// ----- sv/euler_implicit_species_update.sv -----
`timescale 1ns / 1ps
// Top level of the semi-implicit species update block.
// Instantiates eisu_ctrl and eisu_datapath; depends on eisu_pkg.
// One species word is processed at a time. The processing time is set by up to three
// 128-by-64-bit divisions on one shared radix-two divider (two when the net rate is
// zero), each preceded by a 64-by-64-bit product built from four 32-by-32 partial
// products on one multiplier. A finished result waits in an output register, so the
// next input word is taken while the previous one is still unclaimed.
module euler_implicit_species_update import eisu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_word_t        in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_word_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  eisu_cmd_t    cmd;
  eisu_status_t status;

  eisu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  eisu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- bench/tb_euler_implicit_species_update.sv -----
`timescale 1ns / 1ps
// Testbench for euler_implicit_species_update: drives species words, predicts each
// result in fixed point and compares it as a whole word. Depends on eisu_pkg and the RTL.
module tb_euler_implicit_species_update;
  import eisu_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  in_word_t        in_word_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_word_t       out_word_o;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  logic [CfgW-1:0]  tau_factor;
  logic [DataW-1:0] min_step;
  out_word_t        pending_words[$];
  int unsigned      mismatch_cnt;
  int unsigned      idle_cycles;
  bit               stall_en;

  euler_implicit_species_update i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [DataW-1:0] wide_quotient(logic [AccW-1:0] dividend,
                                                     logic [DataW-1:0] divisor);
    if (divisor == '0 || dividend[AccW-1:DataW] >= divisor) begin
      return AllOnes;
    end
    return DataW'(dividend / AccW'(divisor));
  endfunction

  function automatic logic [DataW-1:0] chem_timescale(logic [DataW-1:0] rho,
                                                      logic [DataW-1:0] rate);
    logic [AccW-1:0] scaled;
    scaled = (AccW'(rho) * AccW'(tau_factor)) << 16;
    return wide_quotient(scaled, rate);
  endfunction

  function automatic out_word_t predict_species(in_word_t w);
    out_word_t        r;
    logic [DataW-1:0] prod;
    logic [DataW-1:0] dest;
    logic [DataW-1:0] q;
    logic [DataW-1:0] t;
    logic [DataW:0]   sum;
    logic [AccW-1:0]  p;
    prod = '0;
    dest = '0;
    if (w.net_rate[DataW-1]) begin
      dest = -w.net_rate;
    end else begin
      prod = w.net_rate;
    end
    if (dest != '0) begin
      t = chem_timescale(w.density_in, dest);
      if (t < min_step) min_step = t;
    end
    if (prod != '0) begin
      t = chem_timescale((w.density_in > RhoRepMin) ? w.density_in : RhoRepMin, prod);
      if (t < min_step) min_step = t;
    end
    p = AccW'(w.sub_step) * AccW'(dest);
    q = wide_quotient(p, (w.density_in > 1) ? w.density_in : DataW'(1));
    sum = {1'b0, OneQ40} + {1'b0, q};
    q = sum[DataW] ? AllOnes : sum[DataW-1:0];
    p = AccW'(w.sub_step) * AccW'(prod);
    t = (p[AccW-1:40] >= AccW'(AllOnes) + 1) ? AllOnes : p[103:40];
    if (p[AccW-1:104] != '0) t = AllOnes;
    sum = {1'b0, w.density_in} + {1'b0, t};
    t = sum[DataW] ? AllOnes : sum[DataW-1:0];
    r.density_out = wide_quotient(AccW'(t) << 40, q);
    r.last_out = w.last_species;
    r.next_step = '0;
    if (w.last_species) begin
      r.next_step = (min_step < w.sub_step) ? min_step : w.sub_step;
      min_step = AllOnes;
    end
    return r;
  endfunction

  // Valid stays high after the accept; callers that pause drop it first.
  task automatic send_species(in_word_t w);
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_words.push_back(predict_species(w));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_factor(logic [CfgW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    tau_factor = value;
  endtask

  function automatic logic [DataW-1:0] rand_wide();
    logic [DataW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = AllOnes;
      2: v = v >> $urandom_range(0, 63);
      3: v = DataW'($urandom_range(0, 200));
      default: v = v >> $urandom_range(16, 40);
    endcase
    return v;
  endfunction

  function automatic in_word_t rand_species();
    in_word_t w;
    w.density_in   = rand_wide();
    w.net_rate     = rand_wide();
    if ($urandom_range(0, 1)) w.net_rate = -w.net_rate;
    if ($urandom_range(0, 15) == 0) w.net_rate = {1'b1, 63'd0};
    w.sub_step     = rand_wide();
    w.last_species = ($urandom_range(0, 5) == 0);
    return w;
  endfunction

  task automatic test_directed();
    in_word_t w;
    logic [DataW-1:0] vals[5];
    vals = '{64'd0, 64'd1, 64'd110, OneQ40, AllOnes};
    for (int i = 0; i < 5; i++) begin
      w.density_in   = vals[i];
      w.net_rate     = (i % 2) ? -$signed(vals[4 - i]) : vals[4 - i];
      w.sub_step     = vals[(i + 2) % 5];
      w.last_species = (i == 4);
      send_species(w);
    end
    w = '{density_in: OneQ40, net_rate: '0, sub_step: OneQ40, last_species: 1'b1};
    send_species(w);
    w = '{density_in: AllOnes, net_rate: {1'b1, 63'd0}, sub_step: AllOnes,
          last_species: 1'b0};
    send_species(w);
    w = '{density_in: 64'd5, net_rate: 64'h7FFF_FFFF_FFFF_FFFF, sub_step: AllOnes,
          last_species: 1'b1};
    send_species(w);
    w = '{density_in: OneQ40, net_rate: -$signed(OneQ40), sub_step: OneQ40 >> 4,
          last_species: 1'b0};
    send_species(w);
    w.last_species = 1'b1;
    send_species(w);
  endtask

  task automatic test_random_bursts(int unsigned count);
    int unsigned sent;
    int unsigned gap;
    sent = 0;
    while (sent < count) begin
      for (int b = $urandom_range(1, 12); b > 0 && sent < count; b--) begin
        send_species(rand_species());
        sent++;
      end
      gap = $urandom_range(0, 3) * $urandom_range(0, 40);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic test_quiet_pause();
    wait_drained();
    test_random_bursts(30);
  endtask

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result word %h", out_word_o);
      end else begin
        exp_w = pending_words.pop_front();
        if (exp_w !== out_word_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch density exp %h got %h", exp_w.density_out,
                     out_word_o.density_out);
            $display("  next_step exp %h got %h, last exp %b got %b", exp_w.next_step,
                     out_word_o.next_step, exp_w.last_out, out_word_o.last_out);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!stall_en) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb_euler_implicit_species_update NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    out_ready_i  = 1'b1;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    tau_factor   = CTauReset;
    min_step     = AllOnes;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    stall_en     = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    stall_en = 1'b1;
    test_random_bursts(300);
    write_factor('0);
    test_random_bursts(100);
    write_factor('1);
    test_directed();
    test_random_bursts(200);
    test_quiet_pause();
    write_factor(32'h0100_0000);
    stall_en = 1'b0;
    test_random_bursts(150);
    write_factor(CTauReset);
    stall_en = 1'b1;
    test_random_bursts(130);
    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("tb_euler_implicit_species_update OK");
    end else begin
      $display("tb_euler_implicit_species_update NOT OK");
    end
    $finish;
  end

endmodule
